@@ hw/rtl/oledfb_pkg.sv @@
package oledfb_pkg;

  // Input item action codes
  localparam logic [2:0] ACT_DRAW    = 3'd0;
  localparam logic [2:0] ACT_COLUMN  = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_REFRESH = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDR  = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  // Width of a framebuffer index before it is trimmed to the memory depth
  localparam int IDX_W = 11;

  // Bus bytes
  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [4:0] CMD_PAGE_BASE = 5'b10110;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;

  // Line sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ARMED,
    PH_S0,
    PH_S1,
    PH_S2,
    PH_BL,
    PH_BH,
    PH_A0,
    PH_A1,
    PH_A2,
    PH_P0,
    PH_P1,
    PH_P2
  } seq_phase_t;

  // Byte slot within a transaction
  localparam logic [1:0] SLOT_ADDR = 2'd0;
  localparam logic [1:0] SLOT_CTRL = 2'd1;
  localparam logic [1:0] SLOT_BODY = 2'd2;

  // Refresh steps: page command, column high command, column low command, data
  localparam logic [1:0] STEP_PAGE   = 2'd0;
  localparam logic [1:0] STEP_COL_HI = 2'd1;
  localparam logic [1:0] STEP_DATA   = 2'd3;

  typedef struct packed {
    logic       arm;
    logic       refresh;
    logic       tick;
    logic [7:0] cmd_byte;
  } seq_cmd_t;

  typedef struct packed {
    logic busy_now;
    logic busy;
    logic scl;
    logic sda;
  } seq_stat_t;

endpackage

@@ hw/rtl/oledfb_mem.sv @@
module oledfb_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic [AW-1:0] pf_addr,
  output logic [7:0]    pf_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          clr_busy
);
  import oledfb_pkg::*;

  logic [7:0]    mem [DEPTH];
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [7:0]    rd_r;
  logic          rd_fwd_r;
  logic [7:0]    rd_fwd_d_r;
  logic [7:0]    pf_r;
  logic          pf_fwd_r;
  logic [7:0]    pf_fwd_d_r;

  // Zero the array once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign mem_we = clr_busy_r | wr_en;
  assign mem_wa = clr_busy_r ? clr_addr_r : wr_addr;
  assign mem_wd = clr_busy_r ? 8'h00 : wr_data;

  // Read first; forward a same-cycle write to the same byte
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_r       <= mem[rd_addr];
      rd_fwd_r   <= mem_we && (mem_wa == rd_addr);
      rd_fwd_d_r <= mem_wd;
    end
    pf_r       <= mem[pf_addr];
    pf_fwd_r   <= mem_we && (mem_wa == pf_addr);
    pf_fwd_d_r <= mem_wd;
  end

  assign rd_data  = rd_fwd_r ? rd_fwd_d_r : rd_r;
  assign pf_data  = pf_fwd_r ? pf_fwd_d_r : pf_r;
  assign clr_busy = clr_busy_r;

endmodule

@@ hw/rtl/oledfb_seq.sv @@
module oledfb_seq #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64,
  parameter int AW      = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  oledfb_pkg::seq_cmd_t cmd,
  input  logic [7:0]           slave_addr,
  input  logic [7:0]           phase_ticks,
  input  logic [7:0]           pf_data,
  output logic [AW-1:0]        pf_addr,
  output oledfb_pkg::seq_stat_t stat
);
  import oledfb_pkg::*;

  localparam int PAGES = (ROWS + 7) / 8;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  seq_phase_t    phase_r, phase_nxt;
  logic [2:0]    page_r, page_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          rmode_r, rmode_nxt;
  logic [1:0]    line_r, line_nxt;
  logic [1:0]    slot_r, slot_nxt;
  logic [1:0]    step_r, step_nxt;

  logic           is_data;
  logic [7:0]     payload;
  logic [CW:0]    col_inc;
  logic           col_more;
  logic           page_more;
  logic [CW-1:0]  pf_col;
  logic [IDX_W-1:0] pf_idx;

  function automatic logic [1:0] phase_level(seq_phase_t ph, logic b);
    case (ph)
      PH_S0:   phase_level = 2'b11;
      PH_S1:   phase_level = 2'b10;
      PH_S2:   phase_level = 2'b00;
      PH_BL:   phase_level = {1'b0, b};
      PH_BH:   phase_level = {1'b1, b};
      PH_A0:   phase_level = 2'b01;
      PH_A1:   phase_level = 2'b11;
      PH_A2:   phase_level = 2'b01;
      PH_P0:   phase_level = 2'b00;
      PH_P1:   phase_level = 2'b10;
      default: phase_level = 2'b11;
    endcase
  endfunction

  always_comb begin
    is_data = rmode_r && (step_r == STEP_DATA);
    if (!rmode_r) begin
      payload = pend_r;
    end else if (step_r == STEP_PAGE) begin
      payload = {CMD_PAGE_BASE, page_r};
    end else if (step_r == STEP_COL_HI) begin
      payload = CMD_COL_HI;
    end else begin
      payload = CMD_COL_LO;
    end
    col_inc   = {1'b0, col_r} + 1'b1;
    col_more  = col_inc < (CW + 1)'(COLUMNS);
    page_more = ({1'b0, page_r} + 4'd1) < 4'(PAGES);
  end

  // Next framebuffer byte the data transaction will load
  assign pf_col  = (slot_r == SLOT_CTRL) ? '0 : col_inc[CW-1:0];
  assign pf_idx  = IDX_W'(page_r) * IDX_W'(COLUMNS) + IDX_W'(pf_col);
  assign pf_addr = pf_idx[AW-1:0];

  always_comb begin
    phase_nxt = phase_r;
    page_nxt  = page_r;
    col_nxt   = col_r;
    shift_nxt = shift_r;
    bit_nxt   = bit_r;
    hold_nxt  = hold_r;
    pend_nxt  = pend_r;
    rmode_nxt = rmode_r;
    line_nxt  = line_r;
    slot_nxt  = slot_r;
    step_nxt  = step_r;
    if (cmd.arm) begin
      rmode_nxt = cmd.refresh;
      pend_nxt  = cmd.cmd_byte;
      page_nxt  = '0;
      step_nxt  = '0;
      slot_nxt  = SLOT_ADDR;
      col_nxt   = '0;
      bit_nxt   = '0;
      hold_nxt  = '0;
      phase_nxt = PH_ARMED;
    end else if (cmd.tick && (phase_r != PH_IDLE)) begin
      if (hold_r != 8'd0) begin
        hold_nxt = hold_r - 8'd1;
      end else begin
        case (phase_r)
          PH_ARMED: phase_nxt = PH_S0;
          PH_S0:    phase_nxt = PH_S1;
          PH_S1:    phase_nxt = PH_S2;
          PH_S2: begin
            slot_nxt  = SLOT_ADDR;
            shift_nxt = slave_addr;
            bit_nxt   = '0;
            phase_nxt = PH_BL;
          end
          PH_BL:    phase_nxt = PH_BH;
          PH_BH: begin
            if (bit_r == 3'd7) begin
              phase_nxt = PH_A0;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              shift_nxt = {shift_r[6:0], 1'b0};
              phase_nxt = PH_BL;
            end
          end
          PH_A0:    phase_nxt = PH_A1;
          PH_A1:    phase_nxt = PH_A2;
          PH_A2: begin
            bit_nxt   = '0;
            phase_nxt = PH_BL;
            if (slot_r == SLOT_ADDR) begin
              slot_nxt  = SLOT_CTRL;
              shift_nxt = is_data ? CTRL_DATA : CTRL_CMD;
            end else if (slot_r == SLOT_CTRL) begin
              slot_nxt = SLOT_BODY;
              if (is_data) begin
                col_nxt   = '0;
                shift_nxt = pf_data;
              end else begin
                shift_nxt = payload;
              end
            end else if (is_data && col_more) begin
              col_nxt   = col_inc[CW-1:0];
              shift_nxt = pf_data;
            end else begin
              phase_nxt = PH_P0;
            end
          end
          PH_P0:    phase_nxt = PH_P1;
          PH_P1:    phase_nxt = PH_P2;
          PH_P2: begin
            slot_nxt = SLOT_ADDR;
            if (!rmode_r) begin
              phase_nxt = PH_IDLE;
            end else if (step_r != STEP_DATA) begin
              step_nxt  = step_r + 2'd1;
              phase_nxt = PH_S0;
            end else if (page_more) begin
              page_nxt  = page_r + 3'd1;
              step_nxt  = '0;
              phase_nxt = PH_S0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          default:  phase_nxt = PH_IDLE;
        endcase
        line_nxt = phase_level(phase_nxt, shift_nxt[7]);
        hold_nxt = (phase_ticks == 8'd0) ? 8'd0 : phase_ticks - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      page_r  <= '0;
      col_r   <= '0;
      shift_r <= '0;
      bit_r   <= '0;
      hold_r  <= '0;
      pend_r  <= '0;
      rmode_r <= 1'b0;
      line_r  <= 2'b11;
      slot_r  <= SLOT_ADDR;
      step_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      page_r  <= page_nxt;
      col_r   <= col_nxt;
      shift_r <= shift_nxt;
      bit_r   <= bit_nxt;
      hold_r  <= hold_nxt;
      pend_r  <= pend_nxt;
      rmode_r <= rmode_nxt;
      line_r  <= line_nxt;
      slot_r  <= slot_nxt;
      step_r  <= step_nxt;
    end
  end

  assign stat.busy_now = (phase_r != PH_IDLE);
  assign stat.busy     = (phase_nxt != PH_IDLE);
  assign stat.scl      = line_nxt[1];
  assign stat.sda      = line_nxt[0];

endmodule

@@ hw/rtl/oled_framebuffer_i2c_refresh.sv @@
// Path: an accepted input item is registered into the work stage, then into the output
//   register, from which its result leaves. Throughput: one item per cycle while
//   out_stall is low; a stalled result holds the output register and then the work
//   stage, after which in_stall rises. Reset: synchronous, active low. After reset
//   the framebuffer is zeroed by a clearing pass over its PAGES*COLUMNS bytes (1024 at
//   the defaults), one byte a cycle on the memory write port; in_stall stays high during the pass.
module oled_framebuffer_i2c_refresh #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [6:0] in_x,
  input  logic [5:0] in_y,
  input  logic       in_mode,
  input  logic [2:0] in_page,
  input  logic [7:0] in_data_byte,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl,
  output logic       out_sda,
  output logic       out_busy_res,
  output logic       out_accepted,
  // Configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import oledfb_pkg::*;

  localparam int PAGES = (ROWS + 7) / 8;
  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [7:0] slave_r;
  logic [7:0] pticks_r;

  // Work stage: the accepted item plus its framebuffer byte
  logic       s_v_r;
  logic [2:0] s_action_r;
  logic [6:0] s_x_r;
  logic [5:0] s_y_r;
  logic       s_mode_r;
  logic [2:0] s_page_r;
  logic [7:0] s_data_r;

  // Output register
  logic       out_v_r;
  logic       out_scl_r;
  logic       out_sda_r;
  logic       out_busy_r;
  logic       out_acc_r;

  logic       out_free;
  logic       s_move;
  logic       in_acc;
  logic       clr_busy;

  logic [2:0]       rd_page;
  logic [IDX_W-1:0] rd_idx;
  logic [2:0]       wr_page;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       rd_data;
  logic [7:0]       pf_data;
  logic [AW-1:0]    pf_addr;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic [7:0]       pix_mask;
  logic             x_ok;
  logic             y_ok;
  logic             page_ok;
  logic             is_xfer;

  seq_cmd_t  seq_cmd;
  seq_stat_t seq_stat;

  function automatic logic [IDX_W-1:0] fb_index(logic [2:0] pg, logic [6:0] col);
    fb_index = IDX_W'(pg) * IDX_W'(COLUMNS) + IDX_W'(col);
  endfunction

  // Register writes land at once; the user must issue them only while the block idles, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r  <= 8'd120;
      pticks_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDR:  slave_r  <= cfg_data;
        CFG_PHASE_TICKS: pticks_r <= cfg_data;
        default:         slave_r  <= slave_r;
      endcase
    end
  end

  // Handshake: the work stage advances whenever the output register is free
  assign out_free = !out_v_r || !out_stall;
  assign s_move   = s_v_r && out_free;
  assign in_stall = clr_busy || (s_v_r && !out_free);
  assign in_acc   = in_valid && !in_stall;

  // Fetch the byte an item may modify while it enters the work stage
  assign rd_page = (in_action == ACT_DRAW) ? in_y[5:3] : in_page;
  assign rd_idx  = fb_index(rd_page, in_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (in_acc) begin
      s_v_r <= 1'b1;
    end else if (s_move) begin
      s_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_action_r <= in_action;
      s_x_r      <= in_x;
      s_y_r      <= in_y;
      s_mode_r   <= in_mode;
      s_page_r   <= in_page;
      s_data_r   <= in_data_byte;
    end
  end

  // Pixel and column writes; out-of-range coordinates drop the write
  assign x_ok     = {2'b00, s_x_r} < 9'(COLUMNS);
  assign y_ok     = {1'b0, s_y_r} < 7'(ROWS);
  assign page_ok  = {1'b0, s_page_r} < 4'(PAGES);
  assign pix_mask = 8'b1 << s_y_r[2:0];
  assign wr_page  = (s_action_r == ACT_DRAW) ? s_y_r[5:3] : s_page_r;
  assign wr_idx   = fb_index(wr_page, s_x_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = s_data_r;
    case (s_action_r)
      ACT_DRAW: begin
        wr_en   = s_move && x_ok && y_ok;
        wr_data = s_mode_r ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
      end
      ACT_COLUMN: begin
        wr_en = s_move && x_ok && page_ok;
      end
      default: wr_en = 1'b0;
    endcase
  end

  oledfb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (rd_idx[AW-1:0]),
    .rd_data  (rd_data),
    .pf_addr  (pf_addr),
    .pf_data  (pf_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_idx[AW-1:0]),
    .wr_data  (wr_data),
    .clr_busy (clr_busy)
  );

  // Arm the sequencer only when idle; a refused request leaves it untouched
  assign is_xfer          = (s_action_r == ACT_SEND) || (s_action_r == ACT_REFRESH);
  assign seq_cmd.arm      = s_move && is_xfer && !seq_stat.busy_now;
  assign seq_cmd.refresh  = (s_action_r == ACT_REFRESH);
  assign seq_cmd.tick     = s_move && (s_action_r == ACT_TICK);
  assign seq_cmd.cmd_byte = s_data_r;

  oledfb_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (seq_cmd),
    .slave_addr  (slave_r),
    .phase_ticks (pticks_r),
    .pf_data     (pf_data),
    .pf_addr     (pf_addr),
    .stat        (seq_stat)
  );

  // Output register: hold while stalled, load the line levels after the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_move) begin
      out_scl_r  <= seq_stat.scl;
      out_sda_r  <= seq_stat.sda;
      out_busy_r <= seq_stat.busy;
      out_acc_r  <= !(is_xfer && seq_stat.busy_now);
    end
  end

  assign out_valid    = out_v_r;
  assign out_scl      = out_scl_r;
  assign out_sda      = out_sda_r;
  assign out_busy_res = out_busy_r;
  assign out_accepted = out_acc_r;

endmodule

@@ hw/rtl/oledfb_checker.sv @@
module oledfb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_scl,
  input logic out_sda,
  input logic out_busy_res,
  input logic out_accepted
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable({out_scl, out_sda, out_busy_res, out_accepted}))
    else $error("result changed while stalled");

  // A request is refused only while a transfer runs, and it does not end it
  a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_busy_res)
    else $error("request refused while idle");

  // An idle link has both lines high
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl && out_sda)
    else $error("idle link with a line low");

  // The clearing pass holds off input right after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("input taken during the clearing pass");

endmodule

bind oled_framebuffer_i2c_refresh oledfb_checker u_oledfb_checker (.*);
